[rtl/core/port_bitmap_allocator_macros.svh]
// Assertion macros shared by the port bitmap allocator checker.
// Depends on signals named clk and rst_n in the scope where a macro is used.
`ifndef PORT_BITMAP_ALLOCATOR_MACROS_SVH
`define PORT_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pba_pkg.sv]
// Package for the port bitmap allocator: action codes, channel payload types
// and reset constants. No dependencies.
`default_nettype none

package pba_pkg;

    localparam int PORT_W = 16;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RESERVE = 2'd1,
        ACT_FREE    = 2'd2
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [PORT_W-1:0]   port_number;
    } pba_req_t;

    typedef struct packed {
        logic [PORT_W-1:0]   result_port;
        logic                success;
    } pba_rsp_t;

    localparam logic [PORT_W-1:0] DYN_FIRST_RESET = 16'd49152;
    localparam logic [PORT_W-1:0] CURSOR_RESET    = 16'd49151;

endpackage

`default_nettype wire

[rtl/core/pba_chan_if.sv]
// Valid/ready channel interface used by every port of the allocator.
// The payload type is a parameter; no package dependency.
`default_nettype none

interface pba_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/pba_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/port_bitmap_allocator.sv]
// Top level of the port bitmap allocator: occupancy map in one RAM, next-fit
// cursor and result register. Depends on pba_pkg, pba_chan_if and pba_ram.
//
//   Channel  Direction  Payload                         Transfer when
//   -------  ---------  ------------------------------  ------------------
//   req      in         action, port_number             req.valid & ready
//   rsp      out        result_port, success            rsp.valid & ready
//   cfg      in         dynamic_first_port (16 bits)    cfg.valid & ready
//
// Reserve, free, an unknown action and an allocate with an empty dynamic
// range read the map word when taken, then modify, write it back and load
// the result. Allocate-dynamic scans map words through the RAM read port,
// one word per cycle while the result register is free, from the next-fit
// start word until a word has a free port or the whole range has been seen.
// After reset a clearing pass writes zero to all MAP_WORDS words; no request
// is taken until it ends, while cfg is always ready. A finished result waits
// in an output register; a new request can be taken during that wait, but
// it goes no further than its map read until the result register frees.
`default_nettype none

module port_bitmap_allocator #(
    // Both must be powers of two.
    parameter int PORT_COUNT = 65536,
    parameter int WORD_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    pba_chan_if.sink    req,
    pba_chan_if.source  rsp,
    pba_chan_if.sink    cfg
);
    import pba_pkg::*;

    localparam int PORT_BITS = $clog2(PORT_COUNT);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int MAP_WORDS = PORT_COUNT / WORD_BITS;
    localparam int ADDR_W    = PORT_BITS - BIT_W;
    localparam logic [ADDR_W-1:0] LAST_WORD  = ADDR_W'(MAP_WORDS - 1);
    localparam logic [PORT_W:0]   PORT_LIMIT = (PORT_W + 1)'(PORT_COUNT);

    // One-hot control states.
    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_SCAN  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [PORT_W-1:0]   dyn_first_reg, dyn_first_next;
    logic [PORT_W-1:0]   cursor_reg, cursor_next;
    logic                rsp_valid_reg, rsp_valid_next;
    pba_rsp_t            rsp_data_reg, rsp_data_next;

    // Per-item working registers.
    action_t             act_reg, act_next;
    logic [PORT_W-1:0]   port_reg, port_next;
    logic [ADDR_W-1:0]   word_reg, word_next;
    logic                wrap_reg, wrap_next;
    logic [ADDR_W-1:0]   start_word_reg, start_word_next;
    logic [BIT_W-1:0]    start_bit_reg, start_bit_next;

    // Map RAM access.
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_BITS-1:0] ram_rd_data;

    logic                req_fire;
    logic                rsp_free;
    logic                rsp_load;
    logic [PORT_W-1:0]   first_eff;
    logic                range_empty;
    logic [PORT_W:0]     cursor_inc;
    logic [PORT_W-1:0]   start_port;
    logic [ADDR_W-1:0]   first_word;
    logic [BIT_W-1:0]    first_bit;
    logic [ADDR_W-1:0]   req_word;
    logic [WORD_BITS-1:0] word_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic                found;
    logic [BIT_W-1:0]    found_bit;
    logic [PORT_W-1:0]   found_port;
    logic [ADDR_W-1:0]   scan_next_word;
    logic [ADDR_W-1:0]   port_word;
    logic [WORD_BITS-1:0] port_mask;
    logic                port_in_space;
    logic                port_taken;

    pba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rd_data)
    );

    // Requests are taken only when no item is in flight; the read-modify-write
    // of one item therefore never overlaps the read of the next.
    assign req.ready   = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    assign req_fire = req.valid && req.ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;

    // A first port of zero is treated as one so port zero is never allocated.
    assign first_eff   = (dyn_first_reg == '0) ? PORT_W'(1) : dyn_first_reg;
    assign range_empty = ({1'b0, first_eff} >= PORT_LIMIT);
    assign first_word  = first_eff[PORT_BITS-1:BIT_W];
    assign first_bit   = first_eff[BIT_W-1:0];

    // Next-fit start: one past the cursor, folded back to the first dynamic
    // port when it leaves the dynamic range.
    assign cursor_inc = {1'b0, cursor_reg} + (PORT_W + 1)'(1);
    assign start_port = (cursor_inc >= PORT_LIMIT || cursor_inc < {1'b0, first_eff})
                        ? first_eff : cursor_inc[PORT_W-1:0];

    assign req_word = req.payload.port_number[PORT_BITS-1:BIT_W];

    // Scan window within the current word. The first dynamic word is cut below
    // the first port; the start word is cut below the start bit on the first
    // pass and at or above it after the search has wrapped.
    always_comb
    begin
        word_mask = '1;
        if (word_reg == first_word)
        begin
            word_mask &= ({WORD_BITS{1'b1}} << first_bit);
        end
        if (word_reg == start_word_reg)
        begin
            if (wrap_reg)
            begin
                word_mask &= ~({WORD_BITS{1'b1}} << start_bit_reg);
            end
            else
            begin
                word_mask &= ({WORD_BITS{1'b1}} << start_bit_reg);
            end
        end
    end

    assign free_bits = ~ram_rd_data & word_mask;
    assign found     = |free_bits;

    // Lowest free bit of the window.
    always_comb
    begin
        found_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                found_bit = BIT_W'(i);
            end
        end
    end

    assign found_port     = PORT_W'({word_reg, found_bit});
    assign scan_next_word = (word_reg == LAST_WORD) ? first_word : word_reg + ADDR_W'(1);

    assign port_word     = port_reg[PORT_BITS-1:BIT_W];
    assign port_mask     = WORD_BITS'(1) << port_reg[BIT_W-1:0];
    assign port_in_space = ({1'b0, port_reg} < PORT_LIMIT);
    assign port_taken    = |(ram_rd_data & port_mask);

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        cursor_next     = cursor_reg;
        act_next        = act_reg;
        port_next       = port_reg;
        word_next       = word_reg;
        wrap_next       = wrap_reg;
        start_word_next = start_word_reg;
        start_bit_next  = start_bit_reg;
        rsp_load        = 1'b0;
        rsp_data_next   = rsp_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = word_reg;
        ram_wdata       = ram_rd_data;
        ram_re          = 1'b0;
        ram_raddr       = word_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (req_fire)
                begin
                    act_next  = req.payload.action;
                    port_next = req.payload.port_number;
                    ram_re    = 1'b1;
                    if (req.payload.action == ACT_ALLOC && !range_empty)
                    begin
                        ram_raddr       = start_port[PORT_BITS-1:BIT_W];
                        cursor_next     = start_port;
                        start_word_next = start_port[PORT_BITS-1:BIT_W];
                        start_bit_next  = start_port[BIT_W-1:0];
                        word_next       = start_port[PORT_BITS-1:BIT_W];
                        wrap_next       = 1'b0;
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        ram_raddr  = req_word;
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                if (rsp_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                    ram_waddr  = port_word;
                    unique case (act_reg)
                        ACT_RESERVE:
                        begin
                            rsp_data_next.result_port = port_reg;
                            rsp_data_next.success     = port_in_space && !port_taken;
                            ram_we    = port_in_space && !port_taken;
                            ram_wdata = ram_rd_data | port_mask;
                        end
                        ACT_FREE:
                        begin
                            rsp_data_next.result_port = port_reg;
                            rsp_data_next.success     = port_in_space;
                            ram_we    = port_in_space;
                            ram_wdata = ram_rd_data & ~port_mask;
                        end
                        default:
                        begin
                            // Allocate with an empty dynamic range, or an
                            // unknown action: nothing changes.
                            rsp_data_next.result_port = '0;
                            rsp_data_next.success     = 1'b0;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (rsp_free)
                begin
                    if (found)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = word_reg;
                        ram_wdata   = ram_rd_data | (WORD_BITS'(1) << found_bit);
                        cursor_next = found_port;
                        rsp_load    = 1'b1;
                        rsp_data_next.result_port = found_port;
                        rsp_data_next.success     = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else if (wrap_reg && word_reg == start_word_reg)
                    begin
                        // Whole dynamic range seen once: allocation fails and
                        // the cursor keeps the advanced start port.
                        rsp_load   = 1'b1;
                        rsp_data_next.result_port = '0;
                        rsp_data_next.success     = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = scan_next_word;
                        word_next = scan_next_word;
                        wrap_next = wrap_reg || (word_reg == LAST_WORD);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign dyn_first_next = cfg.valid ? cfg.payload : dyn_first_reg;
    assign rsp_valid_next = rsp_load || (rsp_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            dyn_first_reg <= DYN_FIRST_RESET;
            cursor_reg    <= CURSOR_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            dyn_first_reg <= dyn_first_next;
            cursor_reg    <= cursor_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg   <= rsp_data_next;
        act_reg        <= act_next;
        port_reg       <= port_next;
        word_reg       <= word_next;
        wrap_reg       <= wrap_next;
        start_word_reg <= start_word_next;
        start_bit_reg  <= start_bit_next;
    end

endmodule

`default_nettype wire

[rtl/core/pba_checker.sv]
// Port-level checker for the port bitmap allocator, bound to its top level.
// Depends on pba_pkg and port_bitmap_allocator_macros.svh.
`default_nettype none
`include "port_bitmap_allocator_macros.svh"

module pba_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [1:0]  req_action,
    input  logic [15:0] req_port,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [15:0] rsp_port,
    input  logic        rsp_success
);
    import pba_pkg::*;

    logic        req_fire;
    logic        rsp_fire;
    logic [1:0]  cnt_reg;
    logic [1:0]  last_act_reg;
    logic [15:0] last_port_reg;
    logic        single;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;
    assign single   = (cnt_reg == 2'd1);

    // Items taken whose result has not yet been transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            last_act_reg  <= '0;
            last_port_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_reg + {1'b0, req_fire} - {1'b0, rsp_fire};
            if (req_fire)
            begin
                last_act_reg  <= req_action;
                last_port_reg <= req_port;
            end
        end
    end

    `PBA_ASSERT_NOW(a_rsp_has_item, rsp_valid, cnt_reg != 2'd0,
        "result shown with no request outstanding")

    `PBA_ASSERT_NOW(a_one_in_flight, req_fire, cnt_reg != 2'd2,
        "request taken while another is still being processed")

    `PBA_ASSERT_NOW(a_named_port_echo,
        rsp_valid && single && (last_act_reg == ACT_RESERVE || last_act_reg == ACT_FREE),
        rsp_port == last_port_reg,
        "reserve or free result does not return the requested port")

    `PBA_ASSERT_NOW(a_alloc_port,
        rsp_valid && single && last_act_reg == ACT_ALLOC,
        (rsp_success && rsp_port != 16'd0) || (!rsp_success && rsp_port == 16'd0),
        "allocation result port inconsistent with its success flag")

    `PBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_port) && $stable(rsp_success),
        "stalled result changed")

endmodule

bind port_bitmap_allocator pba_checker u_pba_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_action  (req.payload.action),
    .req_port    (req.payload.port_number),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_port    (rsp.payload.result_port),
    .rsp_success (rsp.payload.success)
);

`default_nettype wire

[verif/port_map_checker.sv]
`timescale 1ns / 100ps
// Response checker for the port bitmap allocator: mirrors the occupancy map and
// the next-fit cursor, predicts each response and compares it. Uses pba_pkg.

module port_map_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic                       req_ready,
    input  pba_pkg::pba_req_t          req_data,
    input  logic                       rsp_valid,
    input  logic                       rsp_ready,
    input  pba_pkg::pba_rsp_t          rsp_data,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [pba_pkg::PORT_W-1:0] cfg_data,
    output int                         mismatch_count,
    output int                         responses_awaited
);
    import pba_pkg::*;

    localparam int unsigned TOTAL_PORTS = 65536;

    bit                port_taken [0:TOTAL_PORTS-1];
    logic [PORT_W-1:0] search_pos;
    logic [PORT_W-1:0] dyn_first;
    pba_rsp_t          pending_responses [$];
    int                error_total = 0;

    // One line per mismatch, and every mismatch is counted.
    task automatic report_mismatch(input string msg);
        error_total++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // Applies one request to the mirrored state and returns its response.
    function automatic pba_rsp_t apply_port_request(input pba_req_t r);
        pba_rsp_t    res;
        int unsigned lowest;
        int unsigned span;
        int unsigned p;
        int unsigned i;
        res = '0;
        case (r.action)
            ACT_ALLOC:
            begin
                lowest = (dyn_first == 0) ? 1 : int'(dyn_first);
                if (lowest < TOTAL_PORTS)
                begin
                    span = TOTAL_PORTS - lowest;
                    p    = int'(search_pos) + 1;
                    if (p >= TOTAL_PORTS || p < lowest)
                        p = lowest;
                    // The cursor moves to the start even when nothing is found.
                    search_pos = p[PORT_W-1:0];
                    for (i = 0; i < span && !res.success; i++)
                    begin
                        if (!port_taken[p])
                        begin
                            port_taken[p]   = 1'b1;
                            search_pos      = p[PORT_W-1:0];
                            res.result_port = p[PORT_W-1:0];
                            res.success     = 1'b1;
                        end
                        else
                        begin
                            p++;
                            if (p >= TOTAL_PORTS)
                                p = lowest;
                        end
                    end
                end
            end
            ACT_RESERVE:
            begin
                res.result_port = r.port_number;
                if (int'(r.port_number) < TOTAL_PORTS && !port_taken[r.port_number])
                begin
                    port_taken[r.port_number] = 1'b1;
                    res.success               = 1'b1;
                end
            end
            ACT_FREE:
            begin
                res.result_port = r.port_number;
                if (int'(r.port_number) < TOTAL_PORTS)
                begin
                    port_taken[r.port_number] = 1'b0;
                    res.success               = 1'b1;
                end
            end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pba_rsp_t want;
        if (!rst_n)
        begin
            foreach (port_taken[k])
                port_taken[k] = 1'b0;
            dyn_first  = DYN_FIRST_RESET;
            search_pos = CURSOR_RESET;
            pending_responses.delete();
            error_total = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                dyn_first = cfg_data;
            if (rsp_valid && rsp_ready)
            begin
                if (pending_responses.size() == 0)
                    report_mismatch($sformatf("response port %0d success %0d with none outstanding",
                                              rsp_data.result_port, rsp_data.success));
                else
                begin
                    want = pending_responses.pop_front();
                    if (rsp_data.result_port !== want.result_port)
                        report_mismatch($sformatf("result_port %0d, expected %0d",
                                                  rsp_data.result_port, want.result_port));
                    if (rsp_data.success !== want.success)
                        report_mismatch($sformatf("success %0d, expected %0d for port %0d",
                                                  rsp_data.success, want.success,
                                                  want.result_port));
                end
            end
            if (req_valid && req_ready)
                pending_responses.push_back(apply_port_request(req_data));
        end
        mismatch_count    <= error_total;
        responses_awaited <= pending_responses.size();
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Top of the port bitmap allocator testbench: clock, reset, stimulus and verdict.
// Depends on pba_pkg, pba_chan_if, port_bitmap_allocator and port_map_checker.

module tb;
    import pba_pkg::*;

    // The action field is two bits wide; its fourth code is not an operation
    // and must be answered with port 0 and no success.
    localparam action_t ACT_UNDEFINED = action_t'(2'd3);

    localparam int IDLE_PCT        = 38;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int PHASE_COUNT     = 8;
    localparam int HOLDOFF_CYCLES  = 400;
    localparam int TAIL_CYCLES     = 40;
    // The limit covers the clearing pass and then every request with the gaps,
    // stalls and hold-off used here, since the stimulus never fills a wide
    // dynamic range, and is many times the slowest correct run.
    localparam int CYCLE_LIMIT     = 300000;

    logic              clk;
    logic              rst_n;
    int                cycle_count   = 0;
    int                req_idle_pct  = IDLE_PCT;
    int                rsp_idle_pct  = IDLE_PCT;
    int                holdoff_token = 0;
    int                holdoff_seen  = 0;
    int                holdoff_left  = 0;
    int                mismatch_count;
    int                responses_awaited;
    // Tracks the dynamic range so that random ports land near it.
    logic [PORT_W-1:0] first_now = DYN_FIRST_RESET;

    pba_chan_if #(.payload_t(pba_req_t))          req_ch ();
    pba_chan_if #(.payload_t(pba_rsp_t))          rsp_ch ();
    pba_chan_if #(.payload_t(logic [PORT_W-1:0])) cfg_ch ();

    port_bitmap_allocator uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    port_map_checker port_map_chk
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_valid         (req_ch.valid),
        .req_ready         (req_ch.ready),
        .req_data          (req_ch.payload),
        .rsp_valid         (rsp_ch.valid),
        .rsp_ready         (rsp_ch.ready),
        .rsp_data          (rsp_ch.payload),
        .cfg_valid         (cfg_ch.valid),
        .cfg_ready         (cfg_ch.ready),
        .cfg_data          (cfg_ch.payload),
        .mismatch_count    (mismatch_count),
        .responses_awaited (responses_awaited)
    );

    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Response side. Ready drops at random, and stays low throughout a hold-off,
    // which the stimulus process requests by bumping holdoff_token. The hold-off
    // is counted here, so the sender keeps offering requests while the
    // result register stays full and the block has to stall its input.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_token != holdoff_seen)
            begin
                holdoff_seen = holdoff_token;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
        end
    end

    // Offers one request after a random gap and returns at the edge where the
    // transfer happens. Valid is left high, so back-to-back requests keep it
    // asserted without a glitch.
    task automatic send_request(input action_t act, input logic [PORT_W-1:0] port);
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= '{action: act, port_number: port};
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stops offering and waits until every response has come back. Every
    // request yields exactly one response, so an empty checker queue means
    // the block is idle.
    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (responses_awaited != 0);
    endtask

    // Changes the dynamic range only while the block is idle.
    task automatic write_first_port(input logic [PORT_W-1:0] value);
        wait_until_drained();
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        first_now = value;
    endtask

    initial
    begin
        logic [PORT_W-1:0] phase_first [0:PHASE_COUNT-1];
        action_t           act;
        logic [PORT_W-1:0] port;
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       pick;

        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.payload <= '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, starting from the reset range of 49152 and up.
        // Allocation starts right above the reset cursor and skips a port
        // that was reserved in between.
        send_request(ACT_ALLOC, 16'd0);
        send_request(ACT_ALLOC, 16'hFFFF);
        send_request(ACT_RESERVE, 16'd49154);
        send_request(ACT_ALLOC, 16'd0);
        // Reserving a taken port fails; freeing a free port still succeeds.
        send_request(ACT_RESERVE, 16'd49154);
        send_request(ACT_FREE, 16'd49154);
        send_request(ACT_FREE, 16'd49154);
        // Extremes of the port field.
        send_request(ACT_RESERVE, 16'd0);
        send_request(ACT_RESERVE, 16'd65535);
        send_request(ACT_FREE, 16'd0);
        send_request(ACT_FREE, 16'd65535);
        send_request(ACT_RESERVE, 16'hAAAA);
        send_request(ACT_RESERVE, 16'h5555);
        // The undefined action changes nothing, whatever the port.
        send_request(ACT_UNDEFINED, 16'hFFFF);
        send_request(ACT_UNDEFINED, 16'd0);
        send_request(ACT_ALLOC, 16'd0);

        // A one-port range at the very top: the cursor sits below the range,
        // so the search jumps to it; the second allocation wraps past the top
        // and finds nothing.
        write_first_port(16'd65535);
        send_request(ACT_ALLOC, 16'd0);
        send_request(ACT_ALLOC, 16'd0);
        send_request(ACT_FREE, 16'd65535);
        send_request(ACT_ALLOC, 16'd0);

        // A range start of zero acts as one, so port 0 is never handed out.
        write_first_port(16'd0);
        send_request(ACT_RESERVE, 16'd2);
        send_request(ACT_ALLOC, 16'd0);
        send_request(ACT_ALLOC, 16'd0);

        // Random part. Each phase uses a different range start; narrow ranges
        // fill up and exercise failed allocations and wrapping, while most
        // reserve and free requests land in or near the range so that
        // allocation runs into holes and taken ports.
        phase_first[0] = 16'd65472;
        phase_first[1] = 16'd1;
        phase_first[2] = 16'd49152;
        phase_first[3] = 16'd65535;
        phase_first[4] = 16'd0;
        phase_first[5] = 16'd64000;
        phase_first[6] = PORT_W'($urandom_range(65535, 1));
        phase_first[7] = 16'd65504;

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            write_first_port(phase_first[ph]);
            // One phase runs with no idling on either side.
            if (ph == 2)
            begin
                req_idle_pct = 0;
                rsp_idle_pct <= 0;
            end
            else
            begin
                req_idle_pct = IDLE_PCT;
                rsp_idle_pct <= IDLE_PCT;
            end
            lo = (first_now == 0) ? 1 : int'(first_now);
            hi = (lo + 255 > 65535) ? 65535 : lo + 255;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 5 && n == 40)
                    holdoff_token <= holdoff_token + 1;
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    act = ACT_ALLOC;
                else if (pick < 72)
                    act = ACT_RESERVE;
                else if (pick < 95)
                    act = ACT_FREE;
                else
                    act = ACT_UNDEFINED;
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    port = PORT_W'($urandom_range(hi, lo));
                else if (pick < 70)
                    port = PORT_W'($urandom_range(65535, 65280));
                else
                    port = PORT_W'($urandom());
                send_request(act, port);
            end
        end

        // Let any stray response show up before the verdict.
        wait_until_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && responses_awaited == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/pba_pkg.sv
rtl/core/pba_chan_if.sv
rtl/core/pba_ram.sv
rtl/core/port_bitmap_allocator.sv
rtl/core/pba_checker.sv
verif/port_map_checker.sv
verif/tb.sv
